// ===== hw/rtl/varint_zigzag_stream_decoder_macros.svh =====
// Assertion macros used by the varint decoder core RTL.
`ifndef VARINT_ZIGZAG_STREAM_DECODER_MACROS_SVH
`define VARINT_ZIGZAG_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define VZZ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define VZZ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define VZZ_ASSERT(lbl, clk, rst_n, prop, msg)
`define VZZ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hw/rtl/vzz_pkg.sv =====
// Types, constants and helpers for the varint/zigzag stream decoder.
package vzz_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned UsedW   = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned ShamtW  = 6;
  localparam int unsigned GroupW  = 7;

  localparam logic [IdxW-1:0]  LastIndex   = 4'd9;
  localparam logic [ByteW-1:0] PayloadMask = 8'h7f;
  localparam int unsigned      ContBitPos  = 7;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StTrunc    = 2'd1,
    StOver     = 2'd2,
    StNoncanon = 2'd3
  } status_e;

  typedef enum logic {
    CfgStrict = 1'b0,
    CfgSigned = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             last_in_buffer;
    logic [ByteW-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic reject_noncanon;
    logic signed_mode;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic [UsedW-1:0]  bytes_used;
    logic [ValueW-1:0] decoded_value;
  } result_t;

  // (v >> 1) ^ -(v & 1)
  function automatic logic [ValueW-1:0] zigzag(input logic [ValueW-1:0] v);
    zigzag = (v >> 1) ^ {ValueW{v[0]}};
  endfunction

endpackage

// ===== hw/rtl/vzz_in_stage.sv =====
// Input word register: holds one accepted byte until the core consumes it.
module vzz_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  vzz_pkg::item_t item_i,
  input  logic          consume_i,
  output logic          valid_o,
  output vzz_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  vzz_pkg::item_t item_q;

  assign ready_o = !valid_q || consume_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (consume_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hw/rtl/vzz_core.sv =====
// Decode core: varint state registers and the one-byte step logic.
`include "varint_zigzag_stream_decoder_macros.svh"

module vzz_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vzz_pkg::cfg_t    cfg_i,
  input  logic             step_i,     // byte in item_i is consumed this cycle
  input  vzz_pkg::item_t   item_i,
  output logic             res_valid_o,
  output vzz_pkg::result_t res_o
);

  logic [vzz_pkg::ValueW-1:0] acc_q, acc_d;
  logic [vzz_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                       skip_q, skip_d;

  logic [vzz_pkg::IdxW-1:0]   idx;
  logic [vzz_pkg::UsedW-1:0]  used;
  logic [vzz_pkg::ShamtW-1:0] shamt;
  logic [vzz_pkg::ValueW-1:0] acc_new;
  logic                       cont;
  logic                       last;
  logic [vzz_pkg::ByteW-1:0]  b;

  assign b     = item_i.data_byte;
  assign last  = item_i.last_in_buffer;
  assign cont  = b[vzz_pkg::ContBitPos];
  assign idx   = (idx_q > vzz_pkg::LastIndex) ? vzz_pkg::LastIndex : idx_q;
  assign used  = idx + 4'd1;
  assign shamt = vzz_pkg::ShamtW'(idx * vzz_pkg::GroupW);
  assign acc_new = acc_q
                 | (vzz_pkg::ValueW'(b & vzz_pkg::PayloadMask) << shamt);

  always_comb begin
    acc_d       = acc_q;
    idx_d       = idx_q;
    skip_d      = skip_q;
    res_valid_o = 1'b0;
    res_o.decoded_value = '0;
    res_o.bytes_used    = used;
    res_o.status        = vzz_pkg::StOk;

    if (skip_q) begin
      // drop tail of a failed varint
      if (!cont || last) begin
        skip_d = 1'b0;
        acc_d  = '0;
        idx_d  = '0;
      end
    end else if (idx == vzz_pkg::LastIndex && b > 8'd1) begin
      res_valid_o      = 1'b1;
      res_o.bytes_used = vzz_pkg::LastIndex + 4'd1;
      res_o.status     = vzz_pkg::StOver;
      acc_d            = '0;
      idx_d            = '0;
      skip_d           = cont && !last;
    end else if (!cont) begin
      res_valid_o = 1'b1;
      acc_d       = '0;
      idx_d       = '0;
      if (cfg_i.reject_noncanon && used > 4'd1 && b == 8'h00) begin
        res_o.status = vzz_pkg::StNoncanon;
      end else begin
        res_o.decoded_value = cfg_i.signed_mode ? vzz_pkg::zigzag(acc_new) : acc_new;
      end
    end else if (last) begin
      res_valid_o  = 1'b1;
      res_o.status = vzz_pkg::StTrunc;
      acc_d        = '0;
      idx_d        = '0;
    end else begin
      acc_d = acc_new;
      idx_d = used;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      idx_q  <= '0;
      skip_q <= 1'b0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      idx_q  <= idx_d;
      skip_q <= skip_d;
    end
  end

  `VZZ_ASSERT_NEVER(a_idx_range, clk_i, rst_ni, idx_q > vzz_pkg::LastIndex,
                    "byte index above 9")
  `VZZ_ASSERT(a_skip_clean, clk_i, rst_ni, skip_q |-> (idx_q == '0 && acc_q == '0),
              "skip with live state")
  `VZZ_ASSERT(a_err_zero, clk_i, rst_ni,
              (res_valid_o && res_o.status != vzz_pkg::StOk) |-> (res_o.decoded_value == '0),
              "error result carries a value")
  `VZZ_ASSERT(a_skip_quiet, clk_i, rst_ni, skip_q |-> !res_valid_o, "result while skipping")
  `VZZ_ASSERT(a_idx_step, clk_i, rst_ni,
              (step_i && !res_valid_o && !skip_q) |=> (idx_q == $past(idx_q) + 4'd1),
              "continuation did not advance index")

endmodule

// ===== hw/rtl/vzz_out_stage.sv =====
// Result word register: holds one decoded result until the sink takes it.
module vzz_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  vzz_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             valid_o,
  output vzz_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  vzz_pkg::result_t res_q;

  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== hw/rtl/varint_zigzag_stream_decoder.sv =====
// Top level: LEB128 varint stream decoder with optional zigzag output.
//
//  Channel   Dir  Words                     Fields (low bit up)
//  s_axis    in   one encoded byte          tdata: data_byte[7:0]; tlast: last_in_buffer
//  m_axis    out  one decoded varint        tdata: decoded_value[63:0], bytes_used[67:64], 0 pad
//                                           tuser: status[1:0]
//  cfg       in   register write            cfg_idx_i 0 reject_noncanon, 1 signed_mode
//
// One byte per cycle sustained while m_axis is not stalled; a result is valid on
// m_axis once its terminating byte has passed the input register, then the result register.
// The step itself is one barrel shift, an OR into the 64-bit accumulator and a
// few compares, done between the input register and the result register.
// Reset clears handshake state, accumulator, byte index, skip flag and config.
// A stalled m_axis holds the result; the held input byte waits with it, even
// one that yields no result, so s_axis backs up after one buffered word.
module varint_zigzag_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,   // last_in_buffer

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // decoded_value[63:0], bytes_used[67:64], zero [71:68]
  output logic [1:0]  m_axis_tuser,   // status[1:0]

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i
);

  vzz_pkg::cfg_t    cfg_q;
  vzz_pkg::item_t   in_item;
  vzz_pkg::item_t   held_item;
  vzz_pkg::result_t core_res;
  vzz_pkg::result_t out_res;
  logic             held_valid;
  logic             core_res_valid;
  logic             out_valid;
  logic             step;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (vzz_pkg::cfg_idx_e'(cfg_idx_i))
        vzz_pkg::CfgStrict: cfg_q.reject_noncanon <= cfg_data_i;
        vzz_pkg::CfgSigned: cfg_q.signed_mode     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.data_byte      = s_axis_tdata;
  assign in_item.last_in_buffer = s_axis_tlast;

  // Held byte steps when the result register can take whatever it produces.
  // Bytes that produce nothing could move past a full result register, but
  // keeping one rule keeps the ready path short.
  assign step = held_valid && (!out_valid || m_axis_tready);

  vzz_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .consume_i (step),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  vzz_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .item_i      (held_item),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  vzz_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && core_res_valid),
    .res_i   (core_res),
    .ready_i (m_axis_tready),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_res.bytes_used, out_res.decoded_value};
  assign m_axis_tuser  = out_res.status;

endmodule

// ===== dv/tb_varint_zigzag_stream_decoder.sv =====
// Self-checking testbench for the LEB128 varint stream decoder with zigzag output.
module tb_varint_zigzag_stream_decoder;

  // Cycles with no word moving on either side before the run is declared hung.
  // The longest legal quiet stretch is a drain or a random send idle or receive stall at 86 percent.
  localparam int StallLimit  = 5000;
  // Input register plus result register, and some margin for a held
  // continuation byte that is still moving through without a result.
  localparam int DrainCycles = 4;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;    // data_byte[7:0]
  logic        s_axis_tlast  = 1'b0;  // last_in_buffer
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;          // decoded_value[63:0], bytes_used[67:64], zero [71:68]
  logic [1:0]  m_axis_tuser;          // status[1:0]
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic        cfg_data_i    = 1'b0;

  varint_zigzag_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Decoder shadow state, advanced once per accepted input word.
  logic [vzz_pkg::ValueW-1:0] acc_r    = '0;
  logic [vzz_pkg::IdxW-1:0]   idx_r    = '0;
  bit                         skip_r   = 1'b0;
  logic                       strict_r = 1'b0;
  logic                       zz_r     = 1'b0;

  vzz_pkg::result_t expected_words[$];
  vzz_pkg::result_t head_word;

  int errors         = 0;
  int bytes_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  function automatic void push_result(input logic [vzz_pkg::ValueW-1:0] v,
                                      input logic [vzz_pkg::UsedW-1:0] n,
                                      input vzz_pkg::status_e st);
    vzz_pkg::result_t r;
    r.decoded_value = v;
    r.bytes_used    = n;
    r.status        = st;
    expected_words.push_back(r);
  endfunction

  // Next-state and result for one input byte.
  function automatic void decode_byte(input logic [7:0] b, input logic lst);
    logic [vzz_pkg::ValueW-1:0] v;
    logic [vzz_pkg::UsedW-1:0]  n;
    bit                         cont;
    cont = b[vzz_pkg::ContBitPos];
    // Dropping the tail of a failed varint: ends on a stop byte or end of buffer.
    if (skip_r) begin
      if (!cont || lst) begin
        skip_r = 1'b0;
        acc_r  = '0;
        idx_r  = '0;
      end
      return;
    end
    // Tenth byte may only carry bit 63; anything above 1 overflows.
    if (idx_r == vzz_pkg::LastIndex && b > 8'd1) begin
      acc_r  = '0;
      idx_r  = '0;
      skip_r = cont && !lst;
      push_result('0, vzz_pkg::UsedW'(vzz_pkg::LastIndex) + 1'b1, vzz_pkg::StOver);
      return;
    end
    acc_r = acc_r | (vzz_pkg::ValueW'(b & vzz_pkg::PayloadMask)
                     << (vzz_pkg::GroupW * idx_r));
    n = idx_r + 1'b1;
    if (!cont) begin
      v     = acc_r;
      acc_r = '0;
      idx_r = '0;
      if (strict_r && n > 1 && b == 8'h00) begin
        push_result('0, n, vzz_pkg::StNoncanon);
      end else if (zz_r) begin
        // zigzag: odd codes are negative
        push_result(v[0] ? ~(v >> 1) : (v >> 1), n, vzz_pkg::StOk);
      end else begin
        push_result(v, n, vzz_pkg::StOk);
      end
    end else if (lst) begin
      acc_r = '0;
      idx_r = '0;
      push_result('0, n, vzz_pkg::StTrunc);
    end else begin
      idx_r = n;
    end
  endfunction

  function automatic void check_field(input string name,
                                      input logic [vzz_pkg::ValueW-1:0] want,
                                      input logic [vzz_pkg::ValueW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Receiver side: random backpressure at the current stall rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: every accepted word must match the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got tdata %h tuser %h",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        head_word = expected_words.pop_front();
        check_field("decoded_value", head_word.decoded_value, m_axis_tdata[63:0]);
        check_field("bytes_used", vzz_pkg::ValueW'(head_word.bytes_used),
                    vzz_pkg::ValueW'(m_axis_tdata[67:64]));
        check_field("tdata pad", '0, vzz_pkg::ValueW'(m_axis_tdata[71:68]));
        check_field("status", vzz_pkg::ValueW'(head_word.status),
                    vzz_pkg::ValueW'(m_axis_tuser));
      end
    end
  end

  // Hang detector: counts cycles with no word moving on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StallLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one byte: random idle gap, then hold valid until accepted.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b, lst);
    bytes_sent++;
  endtask

  // Stop sending and let every expected word come out, plus pipeline slack.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write both registers back to back while the decoder is idle.
  task automatic configure(input logic strict, input logic zz);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= vzz_pkg::CfgStrict;
    cfg_data_i <= strict;
    @(posedge clk_i);
    cfg_idx_i  <= vzz_pkg::CfgSigned;
    cfg_data_i <= zz;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    strict_r = strict;
    zz_r     = zz;
  endtask

  // Reset config: single bytes at both payload extremes, a zero-terminated
  // two-byte varint that is legal while strict mode is off.
  task automatic test_unsigned_basics();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Tenth byte above 1 with continuation set: overflow, then the skip is
  // ended by a byte flagged as the end of the buffer.
  task automatic test_tenth_byte_overflow();
    repeat (9) send_byte(8'hff, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h85, 1'b1);
  endtask

  // Buffer ends mid-varint, and a single byte that closes the buffer cleanly.
  task automatic test_truncation();
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h05, 1'b1);
  endtask

  // Strict mode: a trailing zero byte is rejected, a lone zero is not.
  task automatic test_strict_canonical();
    configure(1'b1, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Signed mode: -1, +1 and the widest 10-byte code (all ones unsigned).
  task automatic test_signed_extremes();
    configure(1'b1, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    repeat (9) send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b0);
  endtask

  // Mostly well-formed varints with random payload; occasional early end of
  // buffer, trailing zeros and oversized tenth bytes.
  task automatic send_random_varint();
    int         len;
    int         k;
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1, 2, 3: len = 1;
      4, 5:       len = 2;
      6:          len = 3;
      7:          len = $urandom_range(4, 8);
      default:    len = $urandom_range(9, 10);
    endcase
    for (k = 0; k < len; k++) begin
      b = 8'($urandom);
      if (k == len - 1) begin
        b[vzz_pkg::ContBitPos] = 1'b0;
        if (len == 10) begin
          b = ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(1));
        end
        if (len > 1 && $urandom_range(5) == 0) b = 8'h00;
      end else begin
        b[vzz_pkg::ContBitPos] = 1'b1;
      end
      send_byte(b, $urandom_range(19) == 0);
    end
  endtask

  task automatic test_random_stream();
    int chunk;
    int goal;
    for (chunk = 0; chunk < 8; chunk++) begin
      configure(chunk[0], chunk[1]);
      // pace rotates so every setting meets two different idling patterns
      case ((chunk + chunk / 4) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      goal = bytes_sent + 225;
      while (bytes_sent < goal) begin
        if ($urandom_range(99) < 85) begin
          send_random_varint();
        end else begin
          // raw noise bytes, end-of-buffer flag at random
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(3) == 0);
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unsigned_basics();
    test_tenth_byte_overflow();
    test_truncation();
    test_strict_canonical();
    test_signed_extremes();
    test_random_stream();
    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/vzz_pkg.sv
hw/rtl/vzz_in_stage.sv
hw/rtl/vzz_core.sv
hw/rtl/vzz_out_stage.sv
hw/rtl/varint_zigzag_stream_decoder.sv
dv/tb_varint_zigzag_stream_decoder.sv
